>>> src/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg - shared definitions for the ASCII integer parser
// Parse phases, status codes, character constants and the digit decoder.
// ----------------------------------------------------------------------------
package aip_pkg;

	localparam int unsigned LENGTH_LIMIT_DEF = 4095;
	localparam int unsigned BASE_W           = 6;
	localparam int unsigned VALUE_W          = 64;
	localparam int unsigned LEN_W            = 12;
	localparam int unsigned DIGIT_W          = 7;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;

	localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 7'd99;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_LO_X  = 8'h78;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		PH_SPACE   = 3'd0,
		PH_SIGN    = 3'd1,
		PH_ZERO    = 3'd2,
		PH_PREFIX  = 3'd3,
		PH_DIGITS  = 3'd4,
		PH_DONE    = 3'd5,
		PH_NOCONV  = 3'd6,
		PH_INVALID = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOCONV  = 2'd1,
		ST_RANGE   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
		logic [DIGIT_W-1:0] d;
		d = NOT_A_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = DIGIT_W'(c - CH_ZERO);
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = DIGIT_W'(c - CH_UP_A) + 7'd10;
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = DIGIT_W'(c - CH_LO_A) + 7'd10;
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_FF || c == CH_LF || c == CH_CR ||
			c == CH_HT || c == CH_VT;
	endfunction

endpackage

>>> src/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser - text to signed 64-bit integer converter
// Parses one byte per cycle unless text_stall is high, with C strtoll rules, and gives one result per text.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters on text_byte/text_valid/text_stall, one byte per transfer; a
//   zero byte ends the text and produces exactly one result transfer on
//   parsed_value/converted_length/status with result_valid/result_stall.
//   Other bytes produce no result.
//   number_base is written through base_wr_en/base_wr_data between texts and
//   is sampled on the first byte of each text (0 = auto octal/decimal/hex).
// Timing:
//   A zero-byte transfer reaches result_valid through the input register and
//   the result register. One byte is taken every cycle unless text_stall is
//   high: the input register feeds a single multiply-add by the base (64 x 6
//   bits) plus overflow check into the parse state and the result register.
// Reset:
//   arst_n clears the parse state, empties both registers and sets the base
//   to 10.
// Stall:
//   A stalled result holds; the byte behind it keeps flowing unless it is
//   itself a terminator, in which case text_stall rises until the result moves.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
	parameter int unsigned LENGTH_LIMIT = aip_pkg::LENGTH_LIMIT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             base_wr_en,
	input  logic [aip_pkg::BASE_W-1:0]       base_wr_data,
	input  logic                             text_valid,
	output logic                             text_stall,
	input  logic [7:0]                       text_byte,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [aip_pkg::VALUE_W-1:0] parsed_value,
	output logic [aip_pkg::LEN_W-1:0]        converted_length,
	output logic [1:0]                       status
);
	import aip_pkg::*;

	localparam int unsigned POS_W = $clog2(LENGTH_LIMIT + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LENGTH_LIMIT);
	localparam int unsigned PROD_W = VALUE_W + BASE_W;

	logic [BASE_W-1:0]  number_base_q;

	logic               valid_s1;
	logic [7:0]         byte_s1;

	phase_t             phase_q;
	logic               neg_q;
	logic [VALUE_W-1:0] acc_q;
	logic               ovf_q;
	logic [BASE_W-1:0]  eff_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   end_q;

	logic               res_valid_q;
	logic [VALUE_W-1:0] res_value_q;
	logic [LEN_W-1:0]   res_len_q;
	status_t            res_status_q;

	phase_t             phase_d;
	logic               neg_d;
	logic [VALUE_W-1:0] acc_d;
	logic               ovf_d;
	logic [BASE_W-1:0]  eff_d;
	logic [POS_W-1:0]   end_d;
	logic               emit;
	logic [VALUE_W-1:0] emit_value;
	logic [POS_W-1:0]   emit_len;
	status_t            emit_status;
	logic               s1_fire;
	logic [POS_W-1:0]   pos_next;

	// ---------------------------------------------------------------- parse
	always_comb begin
		logic [DIGIT_W-1:0] v;
		logic               is_end;
		logic               do_first;
		logic               do_digits;
		logic               em_fixed;
		logic               em_final;
		status_t            fix_status;
		logic [BASE_W-1:0]  b;
		logic [PROD_W-1:0]  prod;
		logic [VALUE_W-1:0] mag;

		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		ovf_d      = ovf_q;
		eff_d      = eff_q;
		end_d      = end_q;
		do_first   = 1'b0;
		do_digits  = 1'b0;
		em_fixed   = 1'b0;
		em_final   = 1'b0;
		fix_status = ST_NOCONV;
		v          = digit_of(byte_s1);
		is_end     = byte_s1 == CH_NUL;

		// base is sampled on the first byte of a text
		if (pos_q == '0 && phase_q == PH_SPACE) begin
			eff_d = number_base_q;
			if (eff_d == BASE_ONE || eff_d > BASE_MAX) begin
				phase_d = PH_INVALID;
			end
		end

		unique case (phase_d)
			PH_SPACE: begin
				if (is_end) begin
					em_fixed = 1'b1;
				end else if (is_space(byte_s1)) begin
					phase_d = PH_SPACE;
				end else if (byte_s1 == CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = PH_SIGN;
				end else if (byte_s1 == CH_PLUS) begin
					phase_d = PH_SIGN;
				end else begin
					do_first = 1'b1;
				end
			end
			PH_SIGN: begin
				do_first = 1'b1;
			end
			PH_ZERO: begin
				if (byte_s1 == CH_LO_X || byte_s1 == CH_UP_X) begin
					eff_d   = BASE_HEX;
					end_d   = pos_q;
					phase_d = PH_PREFIX;
				end else begin
					if (eff_d == BASE_AUTO) begin
						eff_d = BASE_OCT;
					end
					acc_d     = '0;
					phase_d   = PH_DIGITS;
					do_digits = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (!is_end && v < DIGIT_W'(BASE_HEX)) begin
					acc_d   = VALUE_W'(v);
					phase_d = PH_DIGITS;
				end else begin
					acc_d = '0;
					ovf_d = 1'b0;
					if (is_end) begin
						em_final = 1'b1;
					end else begin
						phase_d = PH_DONE;
					end
				end
			end
			PH_DIGITS: begin
				do_digits = 1'b1;
			end
			PH_DONE: begin
				em_final = is_end;
			end
			PH_NOCONV: begin
				em_fixed = is_end;
			end
			PH_INVALID: begin
				em_fixed   = is_end;
				fix_status = ST_INVALID;
			end
			default: begin
				phase_d = PH_SPACE;
			end
		endcase

		// first character after white space and sign
		if (do_first) begin
			if (byte_s1 == CH_ZERO && (eff_d == BASE_AUTO || eff_d == BASE_HEX)) begin
				phase_d = PH_ZERO;
			end else begin
				if (eff_d == BASE_AUTO) begin
					eff_d = BASE_DEC;
				end
				if (!is_end && v < DIGIT_W'(eff_d)) begin
					acc_d   = VALUE_W'(v);
					phase_d = PH_DIGITS;
				end else if (is_end) begin
					em_fixed = 1'b1;
				end else begin
					phase_d = PH_NOCONV;
				end
			end
		end

		// acc * base + digit; overflow leaves the accumulator alone
		b    = (eff_d >= BASE_MIN) ? eff_d : BASE_MIN;
		prod = PROD_W'(acc_d) * PROD_W'(b) + PROD_W'(v);
		if (do_digits) begin
			if (!is_end && v < DIGIT_W'(eff_d)) begin
				if (prod[PROD_W-1:VALUE_W] != '0) begin
					ovf_d = 1'b1;
				end else begin
					acc_d = prod[VALUE_W-1:0];
				end
			end else begin
				end_d = pos_q;
				if (is_end) begin
					em_final = 1'b1;
				end else begin
					phase_d = PH_DONE;
				end
			end
		end

		// saturate and sign
		mag         = ovf_d ? '1 : acc_d;
		emit_value  = '0;
		emit_len    = '0;
		emit_status = fix_status;
		if (em_final) begin
			emit_len = end_d;
			if (neg_d) begin
				if (mag > VALUE_MIN) begin
					emit_value  = VALUE_MIN;
					emit_status = ST_RANGE;
				end else begin
					emit_value  = '0 - mag;
					emit_status = ovf_d ? ST_RANGE : ST_OK;
				end
			end else if (mag > VALUE_MAX) begin
				emit_value  = VALUE_MAX;
				emit_status = ST_RANGE;
			end else begin
				emit_value  = mag;
				emit_status = ST_OK;
			end
		end
		emit = em_fixed || em_final;
	end

	assign pos_next   = (pos_q >= POS_LIMIT) ? POS_LIMIT : pos_q + 1'b1;
	assign s1_fire    = valid_s1 && (!emit || !res_valid_q || !result_stall);
	assign text_stall = valid_s1 && !s1_fire;

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
		end else if (base_wr_en) begin
			number_base_q <= base_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			eff_q   <= '0;
			pos_q   <= '0;
			end_q   <= '0;
		end else if (s1_fire) begin
			if (emit) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				eff_q   <= '0;
				pos_q   <= '0;
				end_q   <= '0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
				eff_q   <= eff_d;
				pos_q   <= pos_next;
				end_q   <= end_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			res_value_q  <= emit_value;
			res_len_q    <= LEN_W'(emit_len);
			res_status_q <= emit_status;
		end
	end

	assign result_valid     = res_valid_q;
	assign parsed_value     = res_value_q;
	assign converted_length = res_len_q;
	assign status           = res_status_q;

endmodule

>>> src/aip_checker.sv
// ----------------------------------------------------------------------------
// aip_checker - port-level assertions for the ASCII integer parser
// Watches the text and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module aip_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             text_valid,
	input logic                             text_stall,
	input logic [7:0]                       text_byte,
	input logic                             result_valid,
	input logic                             result_stall,
	input logic signed [aip_pkg::VALUE_W-1:0] parsed_value,
	input logic [aip_pkg::LEN_W-1:0]        converted_length,
	input logic [1:0]                       status
);
	import aip_pkg::*;

	// stalled result transfer holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(parsed_value) &&
		$stable(converted_length) && $stable(status))
		else $error("stalled result changed");

	// a fresh result follows a terminator transfer through the input and result registers
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(text_valid && !text_stall && text_byte == CH_NUL, 2))
		else $error("result without terminator");

	// failed conversions report zero value and zero length
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_NOCONV || status == ST_INVALID) |->
		parsed_value == '0 && converted_length == '0)
		else $error("failed conversion with nonzero payload");

	// range errors saturate to an extreme
	a_range_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_RANGE |->
		parsed_value == VALUE_MAX || parsed_value == VALUE_MIN)
		else $error("range error not saturated");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (.*);
